FILE: sv/pcrel_pkg.sv
// ----------------------------------------------------------------------------
// pcrel_pkg
// Shared types, encodings and the instruction classifier of the AArch64
// prologue relocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrel_pkg;

  localparam int unsigned MAX_PROLOGUE_BYTES = 200;
  localparam logic [7:0]  MIN_PATCH_RESET    = 8'd20;
  localparam logic [7:0]  WORD_BYTES         = 8'd4;

  // Instruction encodings and masks.
  localparam logic [31:0] NOP_WORD      = 32'hD503201F;
  localparam logic [31:0] ADR_KEEP_MASK = 32'h9F00001F;
  localparam logic [31:0] CB_TB_MASK    = 32'h7E000000;
  localparam logic [31:0] CB_PATTERN    = 32'h34000000;
  localparam logic [31:0] TB_PATTERN    = 32'h36000000;
  localparam logic [31:0] OP26_MASK     = 32'hFC000000;
  localparam logic [31:0] B_PATTERN     = 32'h14000000;
  localparam logic [31:0] BL_PATTERN    = 32'h94000000;
  localparam logic [31:0] BRANCH_REG    = 32'hD4000000;
  localparam logic [31:0] BR_REG_MASK   = 32'hFFFFFC1F;
  localparam logic [31:0] RET_PATTERN   = 32'hD65F0000;
  localparam logic [31:0] BR_PATTERN    = 32'hD61F0000;
  localparam logic [31:0] BLR_PATTERN   = 32'hD63F0000;
  localparam logic [31:0] ADR_MASK      = 32'h9F000000;
  localparam logic [31:0] ADR_PATTERN   = 32'h10000000;
  localparam logic [31:0] ADRP_PATTERN  = 32'h90000000;
  localparam logic [31:0] LDR_MASK      = 32'hFF000000;
  localparam logic [31:0] LDR_PATTERN   = 32'h58000000;
  localparam logic [31:0] MOVW_MASK     = 32'hFF800000;
  localparam logic [31:0] MOVZ_PATTERN  = 32'hD2800000;
  localparam logic [31:0] MOVK_PATTERN  = 32'hF2800000;
  localparam logic [4:0]  SCRATCH_REG   = 5'd16;

  // Step of the jump-back tail that carries the BR word.
  localparam logic [2:0]  TAIL_LAST_STEP = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SOURCE_BASE     = 2'd0;
  localparam logic [1:0] CFG_TRAMPOLINE_BASE = 2'd1;
  localparam logic [1:0] CFG_MIN_PATCH_BYTES = 2'd2;

  typedef enum logic [3:0] {
    KIND_OTHER = 4'd0,
    KIND_NOP   = 4'd1,
    KIND_CBZ   = 4'd2,
    KIND_CBNZ  = 4'd3,
    KIND_TBZ   = 4'd4,
    KIND_TBNZ  = 4'd5,
    KIND_B     = 4'd6,
    KIND_BL    = 4'd7,
    KIND_BR    = 4'd8,
    KIND_BLR   = 4'd9,
    KIND_RET   = 4'd10,
    KIND_ADR   = 4'd11,
    KIND_ADRP  = 4'd12,
    KIND_LDR   = 4'd13,
    KIND_MOVZ  = 4'd14,
    KIND_MOVK  = 4'd15
  } kind_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FAIL  = 2'd1;
  localparam logic [1:0] STATUS_BOUND = 2'd2;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        first;
  } item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [7:0]  out_offset;
    logic [3:0]  kind_code;
    logic [1:0]  status;
    logic        is_tail;
    logic        last;
  } result_t;

  // Outcome of rewriting one word.
  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic        fail;
  } rewrite_t;

  // Request from the item logic to the output stage.
  typedef struct packed {
    logic        load;
    result_t     res;
    logic        tail_start;
    logic [63:0] tail_target;
    logic [7:0]  tail_offset;
  } emit_req_t;

  function automatic kind_t classify(input logic [31:0] w);
    kind_t k;
    logic [31:0] m;
    k = KIND_OTHER;
    m = w & BR_REG_MASK;
    if (w == NOP_WORD) begin
      k = KIND_NOP;
    end else if ((w & CB_TB_MASK) == CB_PATTERN) begin
      k = w[24] ? KIND_CBNZ : KIND_CBZ;
    end else if ((w & CB_TB_MASK) == TB_PATTERN) begin
      k = w[24] ? KIND_TBNZ : KIND_TBZ;
    end else if ((w & OP26_MASK) == B_PATTERN) begin
      k = KIND_B;
    end else if ((w & OP26_MASK) == BL_PATTERN) begin
      k = KIND_BL;
    end else if ((w & OP26_MASK) == BRANCH_REG) begin
      if (m == RET_PATTERN) begin
        k = KIND_RET;
      end else if (m == BR_PATTERN) begin
        k = KIND_BR;
      end else if (m == BLR_PATTERN) begin
        k = KIND_BLR;
      end else begin
        k = KIND_OTHER;
      end
    end else if ((w & ADR_MASK) == ADR_PATTERN) begin
      k = KIND_ADR;
    end else if ((w & ADR_MASK) == ADRP_PATTERN) begin
      k = KIND_ADRP;
    end else if ((w & LDR_MASK) == LDR_PATTERN) begin
      k = KIND_LDR;
    end else if ((w & MOVW_MASK) == MOVZ_PATTERN) begin
      k = KIND_MOVZ;
    end else if ((w & MOVW_MASK) == MOVK_PATTERN) begin
      k = KIND_MOVK;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pcrel_rewrite.sv
// ----------------------------------------------------------------------------
// pcrel_rewrite
// Classifies one instruction word and re-encodes its PC-relative immediate
// for the trampoline address, flagging branches that cannot be moved.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrel_rewrite (
  input  wire logic [31:0]         word,
  input  wire logic [7:0]          offset,
  input  wire logic [63:0]         delta,
  input  wire logic [63:0]         source_base,
  input  wire logic [63:0]         trampoline_base,
  output pcrel_pkg::rewrite_t      rewrite
);

  pcrel_pkg::kind_t kind;
  logic [20:0] imm21;
  logic [32:0] src_here;
  logic [32:0] tramp_here;
  logic [20:0] adr_diff;
  logic [20:0] adrp_diff;
  logic [20:0] page_diff;
  logic        is_tb;
  logic [63:0] imm_ext;
  logic [63:0] diff;
  logic        in_range;
  logic [31:0] adr_word;
  logic [31:0] cb_word;
  logic [31:0] tb_word;

  assign kind = pcrel_pkg::classify(word);
  assign imm21 = {word[23:5], word[30:29]};

  // The source and trampoline share the offset, so ADR only needs the
  // precomputed base difference; ADRP works on page numbers.
  assign src_here   = source_base[32:0] + {25'd0, offset};
  assign tramp_here = trampoline_base[32:0] + {25'd0, offset};
  assign adr_diff   = delta[20:0] + imm21;
  assign adrp_diff  = src_here[32:12] - tramp_here[32:12] + imm21;
  assign page_diff  = (kind == pcrel_pkg::KIND_ADRP) ? adrp_diff : adr_diff;
  assign adr_word   = (word & pcrel_pkg::ADR_KEEP_MASK)
                    | {1'b0, page_diff[1:0], 5'd0, page_diff[20:2], 5'd0};

  assign is_tb   = (kind == pcrel_pkg::KIND_TBZ) || (kind == pcrel_pkg::KIND_TBNZ);
  assign imm_ext = is_tb ? {{48{word[18]}}, word[18:5], 2'b00}
                         : {{43{word[23]}}, word[23:5], 2'b00};
  assign diff    = delta + imm_ext;

  // The byte offset must be a whole word and its top bits a pure sign
  // extension of the field.
  always_comb begin
    if (is_tb) begin
      in_range = (&diff[63:15]) || !(|diff[63:15]);
    end else begin
      in_range = (&diff[63:20]) || !(|diff[63:20]);
    end
    in_range = in_range && (diff[1:0] == 2'b00);
  end

  assign cb_word = {word[31:24], diff[20:2], word[4:0]};
  assign tb_word = {word[31:19], diff[15:2], word[4:0]};

  always_comb begin
    rewrite.kind = kind;
    rewrite.word = word;
    rewrite.fail = 1'b0;
    case (kind)
      pcrel_pkg::KIND_ADR, pcrel_pkg::KIND_ADRP: begin
        rewrite.word = adr_word;
      end
      pcrel_pkg::KIND_LDR, pcrel_pkg::KIND_CBZ, pcrel_pkg::KIND_CBNZ: begin
        rewrite.word = cb_word;
        rewrite.fail = !in_range;
      end
      pcrel_pkg::KIND_TBZ, pcrel_pkg::KIND_TBNZ: begin
        rewrite.word = tb_word;
        rewrite.fail = !in_range;
      end
      pcrel_pkg::KIND_B, pcrel_pkg::KIND_BL: begin
        rewrite.fail = 1'b1;
      end
      default: begin
        rewrite.word = word;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/pcrel_emit.sv
// ----------------------------------------------------------------------------
// pcrel_emit
// Result register and jump-back generator: holds one result word for the
// receiver and plays out the five-word MOVZ/MOVK/BR tail.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrel_emit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pcrel_pkg::emit_req_t  req,
  output logic                       free,
  output logic                       busy,
  output pcrel_pkg::result_t         result,
  output logic                       result_valid,
  input  wire logic                  result_ready
);

  logic [2:0]  tail_step;
  logic [63:0] tail_target;
  logic [7:0]  tail_offset;
  logic [15:0] part;
  logic        tail_is_movz;
  logic        tail_is_br;
  pcrel_pkg::result_t tail_res;

  assign free = !result_valid || result_ready;

  always_comb begin
    case (tail_step[1:0])
      2'd0:    part = tail_target[15:0];
      2'd1:    part = tail_target[31:16];
      2'd2:    part = tail_target[47:32];
      default: part = tail_target[63:48];
    endcase
  end

  assign tail_is_movz = (tail_step == 3'd0);
  assign tail_is_br   = (tail_step == pcrel_pkg::TAIL_LAST_STEP);

  always_comb begin
    tail_res.out_offset = tail_offset + {3'd0, tail_step, 2'b00};
    tail_res.status     = pcrel_pkg::STATUS_OK;
    tail_res.is_tail    = 1'b1;
    tail_res.last       = tail_is_br;
    if (tail_is_br) begin
      tail_res.out_word  = pcrel_pkg::BR_PATTERN | {22'd0, pcrel_pkg::SCRATCH_REG, 5'd0};
      tail_res.kind_code = pcrel_pkg::KIND_BR;
    end else if (tail_is_movz) begin
      tail_res.out_word  = pcrel_pkg::MOVZ_PATTERN
                         | {11'd0, part, pcrel_pkg::SCRATCH_REG};
      tail_res.kind_code = pcrel_pkg::KIND_MOVZ;
    end else begin
      tail_res.out_word  = pcrel_pkg::MOVK_PATTERN
                         | {9'd0, tail_step[1:0], part, pcrel_pkg::SCRATCH_REG};
      tail_res.kind_code = pcrel_pkg::KIND_MOVK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      busy         <= 1'b0;
      tail_step    <= 3'd0;
    end else begin
      if (free) begin
        if (busy) begin
          result       <= tail_res;
          result_valid <= 1'b1;
          tail_step    <= tail_step + 3'd1;
          if (tail_is_br) begin
            busy <= 1'b0;
          end
        end else if (req.load) begin
          result       <= req.res;
          result_valid <= 1'b1;
        end else begin
          result_valid <= 1'b0;
        end
      end
      // A new tail only starts together with the word that precedes it.
      if (req.tail_start) begin
        busy        <= 1'b1;
        tail_step   <= 3'd0;
        tail_target <= req.tail_target;
        tail_offset <= req.tail_offset;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/arm64_pc_relative_relocator_unit.sv
// ----------------------------------------------------------------------------
// arm64_pc_relative_relocator_unit
// Relocates AArch64 prologue words from a source address to a trampoline and
// appends a jump back to the source once enough bytes have been moved.
// ----------------------------------------------------------------------------
// Usage: write source_base, trampoline_base and min_patch_bytes through the
// cfg port while the unit is idle, then stream instruction words on the item
// channel, the first of a run with first set. Each accepted word appears on
// the result channel in the next cycle, rewritten for the trampoline, unless
// the run has already ended, in which case it is consumed without a result.
// When the byte offset reaches min_patch_bytes the word is followed by five
// tail words (MOVZ, three MOVK and BR x16); item_ready stays low while the
// tail generator owns the result register.
// An unmovable branch or an out-of-range offset gives one error word with
// last set and ends the run until the next word with first set.
// Throughput is one word per cycle outside the tail, bounded by the single
// result register: a stalled receiver holds the result and drops item_ready.
// Reset clears the run state and valid flags and loads min_patch_bytes = 20.
// ----------------------------------------------------------------------------
`default_nettype none

module arm64_pc_relative_relocator_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire pcrel_pkg::item_t   item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output pcrel_pkg::result_t      result
);

  logic [63:0] source_base;
  logic [63:0] trampoline_base;
  logic [63:0] delta;
  logic [7:0]  min_patch_bytes;
  logic [7:0]  byte_offset;
  logic        halted;

  logic        accept;
  logic [7:0]  cur_offset;
  logic        cur_halted;
  logic [7:0]  next_offset;
  logic        over_bound;
  logic        error;
  logic        tail;
  logic        emit_free;
  logic        emit_busy;
  pcrel_pkg::rewrite_t   rewrite;
  pcrel_pkg::emit_req_t  req;

  // Configuration; the base difference is kept ready for the rewrite path.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base     <= 64'd0;
      trampoline_base <= 64'd0;
      delta           <= 64'd0;
      min_patch_bytes <= pcrel_pkg::MIN_PATCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcrel_pkg::CFG_SOURCE_BASE: begin
          source_base <= cfg_data;
          delta       <= cfg_data - trampoline_base;
        end
        pcrel_pkg::CFG_TRAMPOLINE_BASE: begin
          trampoline_base <= cfg_data;
          delta           <= source_base - cfg_data;
        end
        pcrel_pkg::CFG_MIN_PATCH_BYTES: begin
          min_patch_bytes <= cfg_data[7:0];
        end
        default: begin
          min_patch_bytes <= min_patch_bytes;
        end
      endcase
    end
  end

  assign item_ready = !emit_busy && emit_free;
  assign accept     = item_valid && item_ready;
  assign cur_offset = item.first ? 8'd0 : byte_offset;
  assign cur_halted = item.first ? 1'b0 : halted;

  pcrel_rewrite u_rewrite (
    .word            (item.instr_word),
    .offset          (cur_offset),
    .delta           (delta),
    .source_base     (source_base),
    .trampoline_base (trampoline_base),
    .rewrite         (rewrite)
  );

  assign over_bound  = ({1'b0, cur_offset} + {1'b0, pcrel_pkg::WORD_BYTES})
                       > 9'(pcrel_pkg::MAX_PROLOGUE_BYTES);
  assign error       = over_bound || rewrite.fail;
  assign next_offset = cur_offset + pcrel_pkg::WORD_BYTES;
  assign tail        = !error && (next_offset >= min_patch_bytes);

  always_comb begin
    req.load              = accept && !cur_halted;
    req.tail_start        = accept && !cur_halted && tail;
    req.tail_target       = source_base + {56'd0, next_offset};
    req.tail_offset       = next_offset;
    req.res.out_offset    = cur_offset;
    req.res.kind_code     = rewrite.kind;
    req.res.is_tail       = 1'b0;
    if (error) begin
      req.res.out_word = 32'd0;
      req.res.status   = over_bound ? pcrel_pkg::STATUS_BOUND : pcrel_pkg::STATUS_FAIL;
      req.res.last     = 1'b1;
    end else begin
      req.res.out_word = rewrite.word;
      req.res.status   = pcrel_pkg::STATUS_OK;
      req.res.last     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= 8'd0;
      halted      <= 1'b0;
    end else if (accept) begin
      if (cur_halted) begin
        byte_offset <= cur_offset;
        halted      <= cur_halted;
      end else if (error) begin
        byte_offset <= cur_offset;
        halted      <= 1'b1;
      end else begin
        byte_offset <= next_offset;
        halted      <= tail;
      end
    end
  end

  pcrel_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .free         (emit_free),
    .busy         (emit_busy),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire
